@@ hdl/tmia_pkg.sv @@
// Package for the typed multi-width integer ALU.
// Holds the word types, action and error codes and the type-tag helpers.
// No dependencies.
package tmia_pkg;

    localparam int DivSteps = 64;

    typedef enum logic [4:0] {
        ACT_ADD    = 5'd0,
        ACT_SUB    = 5'd1,
        ACT_MUL    = 5'd2,
        ACT_DIV    = 5'd3,
        ACT_MOD    = 5'd4,
        ACT_AND    = 5'd5,
        ACT_OR     = 5'd6,
        ACT_XOR    = 5'd7,
        ACT_EQ     = 5'd8,
        ACT_NE     = 5'd9,
        ACT_LT     = 5'd10,
        ACT_LE     = 5'd11,
        ACT_GT     = 5'd12,
        ACT_GE     = 5'd13,
        ACT_SHL    = 5'd14,
        ACT_SHR    = 5'd15,
        ACT_INVERT = 5'd16,
        ACT_NEGATE = 5'd17,
        ACT_INC    = 5'd18,
        ACT_DEC    = 5'd19,
        ACT_COERCE = 5'd20
    } act_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_SIGNED   = 2'd1,
        ERR_RANGE    = 2'd2,
        ERR_DIV_ZERO = 2'd3
    } err_t;

    typedef struct packed {
        logic [4:0]  action;
        logic [63:0] a_value;
        logic [2:0]  a_type;
        logic [63:0] b_value;
        logic [2:0]  b_type;
    } op_t;

    typedef struct packed {
        logic [63:0] result_value;
        logic [2:0]  result_type;
        logic        compare_flag;
        logic [1:0]  error_code;
    } res_t;

    // Mask a value to its type's width, then zero or sign extend it.
    function automatic logic [63:0] extend_val(logic [63:0] v, logic [2:0] t);
        logic [63:0] r;
        case (t[2:1])
            2'd0:    r = t[0] ? {{56{v[7]}}, v[7:0]} : {56'd0, v[7:0]};
            2'd1:    r = t[0] ? {{48{v[15]}}, v[15:0]} : {48'd0, v[15:0]};
            2'd2:    r = t[0] ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] type_width(logic [2:0] t);
        logic [6:0] w;
        case (t[2:1])
            2'd0:    w = 7'd8;
            2'd1:    w = 7'd16;
            2'd2:    w = 7'd32;
            default: w = 7'd64;
        endcase
        return w;
    endfunction

endpackage

@@ hdl/typed_multiwidth_integer_alu.sv @@
// Top level of the typed multi-width integer ALU.
// Depends on tmia_pkg for word types, codes and type-tag helpers.
//
// Usage:
// An operation word enters on op_data with op_valid and is taken at a rising
// edge where op_stall is low. Each word carries an action and two operands
// with 3-bit type tags. One result word per operation leaves on res_data with
// res_valid and is taken at an edge where res_stall is low.
// The pipeline is one decode stage, one multiply stage, 64 restoring-divide
// stages (one quotient bit each, which sets the depth) and the output register,
// which also applies the sign fix.
// Every action runs the same pipeline so results stay in order.
// Throughput is one word per cycle. The whole pipeline advances together;
// when the output register holds a word and res_stall is high, every stage
// holds and op_stall is raised, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline comes up empty and ready.
module typed_multiwidth_integer_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    output logic              op_stall,
    input  tmia_pkg::op_t     op_data,
    output logic              res_valid,
    input  logic              res_stall,
    output tmia_pkg::res_t    res_data
);

    typedef struct packed {
        logic [4:0]  action;
        logic [2:0]  rt;
        logic        flag;
        logic [1:0]  err;
        logic [63:0] r;
        logic [63:0] ma;
        logic [63:0] mb;
        logic        na;
        logic        nb;
        logic [63:0] ub;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] pp_ll;
        logic [31:0] pp_lh;
        logic [31:0] pp_hl;
    } pipe_t;

    localparam logic [63:0] TopBit = 64'h8000_0000_0000_0000;

    logic adv;

    pipe_t d_next, d_reg;
    logic  d_vld_reg;
    pipe_t m_next, m_reg;
    logic  m_vld_reg;
    pipe_t div_next [tmia_pkg::DivSteps];
    pipe_t div_reg  [tmia_pkg::DivSteps];
    logic  div_vld_reg [tmia_pkg::DivSteps];
    tmia_pkg::res_t out_next, out_reg;
    logic  out_vld_reg;

    assign adv       = !(out_vld_reg && res_stall);
    assign op_stall  = !adv;
    assign res_valid = out_vld_reg;
    assign res_data  = out_reg;

    // Decode: extend operands, find the result type and errors, and compute all
    // results other than multiply, divide and modulo.
    always_comb
    begin
        logic [63:0] a, b, ka, kb, ua, ub;
        logic [2:0]  at, bt, rt;
        logic        sg, mism, bad, a_neg, big;
        logic [6:0]  w;
        logic [63:0] wide_w;
        at     = op_data.a_type;
        bt     = op_data.b_type;
        a      = tmia_pkg::extend_val(op_data.a_value, at);
        b      = tmia_pkg::extend_val(op_data.b_value, bt);
        mism   = at[0] != bt[0];
        rt     = (at[2:1] >= bt[2:1]) ? at : bt;
        sg     = rt[0];
        a_neg  = at[0] && a[63];
        ka     = sg ? (a ^ TopBit) : a;
        kb     = sg ? (b ^ TopBit) : b;
        ua     = (sg && a[63]) ? (~a + 64'd1) : a;
        ub     = (sg && b[63]) ? (~b + 64'd1) : b;
        w      = tmia_pkg::type_width(at);
        wide_w = {57'd0, w};
        big    = b >= wide_w;
        bad    = (!at[0] && bt[0] && a[63]) || (a_neg && !bt[0])
                 || (tmia_pkg::extend_val(a, bt) != a);

        d_next        = '0;
        d_next.action = op_data.action;
        d_next.ma     = a;
        d_next.mb     = b;
        d_next.na     = sg && a[63];
        d_next.nb     = sg && b[63];
        d_next.ub     = ub;
        d_next.quo    = ua;
        d_next.rt     = at;
        d_next.err    = tmia_pkg::ERR_OK;

        case (tmia_pkg::act_t'(op_data.action))
            tmia_pkg::ACT_ADD, tmia_pkg::ACT_SUB, tmia_pkg::ACT_MUL,
            tmia_pkg::ACT_DIV, tmia_pkg::ACT_MOD, tmia_pkg::ACT_AND,
            tmia_pkg::ACT_OR, tmia_pkg::ACT_XOR, tmia_pkg::ACT_EQ,
            tmia_pkg::ACT_NE, tmia_pkg::ACT_LT, tmia_pkg::ACT_LE,
            tmia_pkg::ACT_GT, tmia_pkg::ACT_GE:
            begin
                d_next.rt = rt;
                case (tmia_pkg::act_t'(op_data.action))
                    tmia_pkg::ACT_ADD: d_next.r = a + b;
                    tmia_pkg::ACT_SUB: d_next.r = a - b;
                    tmia_pkg::ACT_AND: d_next.r = a & b;
                    tmia_pkg::ACT_OR:  d_next.r = a | b;
                    tmia_pkg::ACT_XOR: d_next.r = a ^ b;
                    tmia_pkg::ACT_EQ:  d_next.flag = ka == kb;
                    tmia_pkg::ACT_NE:  d_next.flag = ka != kb;
                    tmia_pkg::ACT_LT:  d_next.flag = ka < kb;
                    tmia_pkg::ACT_LE:  d_next.flag = ka <= kb;
                    tmia_pkg::ACT_GT:  d_next.flag = ka > kb;
                    tmia_pkg::ACT_GE:  d_next.flag = ka >= kb;
                    default:           d_next.r = '0;
                endcase
                if (op_data.action >= tmia_pkg::ACT_EQ)
                    d_next.r = {63'd0, d_next.flag};
                if (mism)
                    d_next.err = tmia_pkg::ERR_SIGNED;
                else if ((op_data.action == tmia_pkg::ACT_DIV
                          || op_data.action == tmia_pkg::ACT_MOD) && b == '0)
                    d_next.err = tmia_pkg::ERR_DIV_ZERO;
            end
            tmia_pkg::ACT_SHL, tmia_pkg::ACT_SHR:
            begin
                if (bt[0] && b[63])
                    d_next.err = tmia_pkg::ERR_RANGE;
                else if (op_data.action == tmia_pkg::ACT_SHL)
                    d_next.r = big ? '0 : (a << b[5:0]);
                else if (at[0])
                    d_next.r = $unsigned($signed(a) >>> (big ? 6'd63 : b[5:0]));
                else
                    d_next.r = big ? '0 : (a >> b[5:0]);
            end
            tmia_pkg::ACT_INVERT: d_next.r = ~a;
            tmia_pkg::ACT_NEGATE:
            begin
                d_next.r = ~a + 64'd1;
                if (!at[0])
                    d_next.err = tmia_pkg::ERR_SIGNED;
            end
            tmia_pkg::ACT_INC: d_next.r = a + 64'd1;
            tmia_pkg::ACT_DEC: d_next.r = a - 64'd1;
            tmia_pkg::ACT_COERCE:
            begin
                d_next.rt = bt;
                d_next.r  = a;
                if (bad)
                    d_next.err = tmia_pkg::ERR_RANGE;
            end
            default: d_next.err = tmia_pkg::ERR_RANGE;
        endcase
    end

    // Multiply stage: three 32x32 partial products of the low 64 bits.
    always_comb
    begin
        m_next       = d_reg;
        m_next.pp_ll = d_reg.ma[31:0] * d_reg.mb[31:0];
        m_next.pp_lh = 32'(d_reg.ma[31:0] * d_reg.mb[63:32]);
        m_next.pp_hl = 32'(d_reg.ma[63:32] * d_reg.mb[31:0]);
    end

    // Restoring divide: one quotient bit per stage. The first stage also
    // sums the partial products for a multiply.
    always_comb
    begin
        pipe_t       src;
        logic [64:0] t;
        logic        qb;
        for (int k = 0; k < tmia_pkg::DivSteps; k++)
        begin
            src = (k == 0) ? m_reg : div_reg[k - 1];
            if (k == 0 && m_reg.action == tmia_pkg::ACT_MUL)
                src.r = m_reg.pp_ll + {m_reg.pp_lh + m_reg.pp_hl, 32'd0};
            t  = {src.rem, src.quo[63]};
            qb = t >= {1'b0, src.ub};
            div_next[k]     = src;
            div_next[k].rem = qb ? 64'(t - {1'b0, src.ub}) : t[63:0];
            div_next[k].quo = {src.quo[62:0], qb};
        end
    end

    // Sign fix, narrowing to the result type and error masking.
    always_comb
    begin
        pipe_t       s;
        logic [63:0] r;
        s = div_reg[tmia_pkg::DivSteps - 1];
        case (tmia_pkg::act_t'(s.action))
            tmia_pkg::ACT_DIV: r = (s.na != s.nb) ? (~s.quo + 64'd1) : s.quo;
            tmia_pkg::ACT_MOD: r = s.na ? (~s.rem + 64'd1) : s.rem;
            default:           r = s.r;
        endcase
        if (s.err != tmia_pkg::ERR_OK)
        begin
            out_next = '0;
            out_next.error_code = s.err;
        end
        else
        begin
            out_next.result_value = tmia_pkg::extend_val(r, s.rt);
            out_next.result_type  = s.rt;
            out_next.compare_flag = s.flag;
            out_next.error_code   = tmia_pkg::ERR_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < tmia_pkg::DivSteps; k++)
                div_vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            d_vld_reg   <= op_valid;
            m_vld_reg   <= d_vld_reg;
            div_vld_reg[0] <= m_vld_reg;
            for (int k = 1; k < tmia_pkg::DivSteps; k++)
                div_vld_reg[k] <= div_vld_reg[k - 1];
            out_vld_reg <= div_vld_reg[tmia_pkg::DivSteps - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg   <= d_next;
            m_reg   <= m_next;
            for (int k = 0; k < tmia_pkg::DivSteps; k++)
                div_reg[k] <= div_next[k];
            out_reg <= out_next;
        end
    end

endmodule
